// ===== hw/rtl/fsthr_pkg.sv =====
// shared constants and types for the function start table hit recorder
// no dependencies
`default_nettype none
package fsthr_pkg;
  localparam int MAX_STARTS_DEF = 4096;
  localparam int ADDR_BITS_DEF  = 48;
  localparam int REG_W          = 48;

  localparam logic [3:0] ST_CONSUMED = 4'd0;
  localparam logic [3:0] ST_APPENDED = 4'd1;
  localparam logic [3:0] ST_DONE     = 4'd2;
  localparam logic [3:0] ST_ERROR    = 4'd3;
  localparam logic [3:0] ST_FULL     = 4'd4;
  localparam logic [3:0] ST_FIRST    = 4'd5;
  localparam logic [3:0] ST_REPEAT   = 4'd6;
  localparam logic [3:0] ST_NOMATCH  = 4'd7;
  localparam logic [3:0] ST_NOTREADY = 4'd8;

  localparam logic [1:0] REG_TEXT_BASE   = 2'd0;
  localparam logic [1:0] REG_RANGE_START = 2'd1;
  localparam logic [1:0] REG_RANGE_END   = 2'd2;
  localparam logic [1:0] REG_LOAD_SLIDE  = 2'd3;

  // word handed from front to back
  typedef struct packed {
    logic        is_trap;
    logic [7:0]  byte_value;
    logic        last_byte;
    logic [47:0] trap_pc;
  } fsthr_word_t;
endpackage
`default_nettype wire

// ===== hw/rtl/function_start_table_hit_recorder.sv =====
// top level: function start table builder with first-hit trap recorder
// depends on fsthr_pkg, fsthr_front, fsthr_back
`default_nettype none
// A byte word is processed in S_IDLE and its result presented in S_OUT. A trap
// word starts in S_IDLE; each search pass then probes the single table read
// port, S_SRCH then S_RD per probe, up to log2(entries)+1 probes, then makes a
// final read (S_SRCH) and compare (S_CMP); a miss repeats the pass once with pc-4,
// and on a hit S_MARK marks the entry before the result is presented in S_OUT.
// After reset the seen marks are cleared in a sweep over all MAX_STARTS entries,
// during which the front queue holds at most two words and nothing is
// processed; configuration writes are accepted at any time.
module function_start_table_hit_recorder import fsthr_pkg::*; #(
  parameter int MAX_STARTS = MAX_STARTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_req_type,
  input  wire logic [7:0]  in_byte_value,
  input  wire logic        in_last_byte,
  input  wire logic [47:0] in_trap_pc,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       out_status,
  output logic [47:0]      out_resume_pc,
  output logic [11:0]      out_entry_index,
  output logic [11:0]      out_hit_order,
  output logic [47:0]      out_hit_offset,
  output logic [12:0]      out_entry_count,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [47:0] cfg_data
);
  fsthr_word_t in_word, q_word;
  logic q_valid, q_ready;

  assign cfg_ready = 1'b1;
  assign in_word = '{is_trap: in_req_type, byte_value: in_byte_value,
                     last_byte: in_last_byte, trap_pc: in_trap_pc};

  // front queue
  fsthr_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_word,
    .q_valid, .q_ready, .q_word
  );

  // back engine
  fsthr_back #(.MAX_STARTS(MAX_STARTS)) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_word,
    .cfg_valid, .cfg_index, .cfg_hit(1'b1), .cfg_data,
    .out_valid, .out_ready, .out_status, .out_resume_pc, .out_entry_index,
    .out_hit_order, .out_hit_offset, .out_entry_count
  );
endmodule
`default_nettype wire

// ===== hw/rtl/fsthr_front.sv =====
// front: accepts input words into a two-entry queue
// depends on fsthr_pkg
`default_nettype none
module fsthr_front import fsthr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire fsthr_word_t in_word,
  output logic             q_valid,
  input  wire logic        q_ready,
  output fsthr_word_t      q_word
);
  fsthr_word_t mem_r [2];
  logic [1:0] wp_r, rp_r, wp_nxt, rp_nxt;
  logic push, pop;

  assign in_ready = (wp_r - rp_r) != 2'd2;
  assign q_valid  = wp_r != rp_r;
  assign q_word   = mem_r[rp_r[0]];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;
  assign wp_nxt   = wp_r + {1'b0, push};
  assign rp_nxt   = rp_r + {1'b0, pop};

  // queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 2'd0;
      rp_r <= 2'd0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r[0]] <= in_word;
  end
endmodule
`default_nettype wire

// ===== hw/rtl/fsthr_back.sv =====
// back: decodes deltas, builds table, runs binary search for traps
// depends on fsthr_pkg
`default_nettype none
module fsthr_back import fsthr_pkg::*; #(
  parameter int MAX_STARTS = MAX_STARTS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 q_valid,
  output logic                      q_ready,
  input  wire fsthr_word_t          q_word,
  input  wire logic                 cfg_valid,
  input  wire logic [1:0]           cfg_index,
  input  wire logic                 cfg_hit,
  input  wire logic [REG_W-1:0]     cfg_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [3:0]                out_status,
  output logic [47:0]               out_resume_pc,
  output logic [11:0]               out_entry_index,
  output logic [11:0]               out_hit_order,
  output logic [47:0]               out_hit_offset,
  output logic [12:0]               out_entry_count
);
  localparam int ADDR_BITS = ADDR_BITS_DEF;
  localparam int IW = $clog2(MAX_STARTS);
  localparam int CW = IW + 1;
  localparam logic [CW-1:0] CAP = CW'(MAX_STARTS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SRCH = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_MARK = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [ADDR_BITS-1:0] start_mem [MAX_STARTS];
  logic                 seen_mem  [MAX_STARTS];

  logic [47:0] range_start_r, range_end_r, load_slide_r;
  logic [63:0] accum_r;
  logic [6:0]  shift_r;
  logic [ADDR_BITS-1:0] run_r;
  logic done_r, err_r;
  logic [CW-1:0] count_r, hits_r;
  logic [2:0] state_r;
  logic [CW-1:0] lo_r, hi_r;
  logic [ADDR_BITS-1:0] key_r, rd_r;
  logic retry_r, seen_rd_r;
  logic [ADDR_BITS:0] pc_r;
  logic [3:0] st_r;
  logic [47:0] res_r, off_r;
  logic [11:0] idx_r, ord_r;
  logic [12:0] cnt_out_r;
  logic clr_r;
  logic [IW-1:0] clr_ptr_r;

  // byte path combinational
  logic [63:0] acc_nxt, delta;
  logic [6:0]  sh_nxt;
  logic [ADDR_BITS:0] sum;
  logic        ovf, in_rng;
  logic [CW-1:0] mid;
  logic [ADDR_BITS-1:0] pc_trunc;

  assign acc_nxt = accum_r | (shift_r < 7'd64 ?
                   ({57'd0, q_word.byte_value[6:0]} << shift_r[5:0]) : 64'd0);
  assign sh_nxt  = shift_r + 7'd7;
  assign delta   = acc_nxt;
  assign sum     = {1'b0, run_r} + delta[ADDR_BITS:0];
  assign ovf     = (ADDR_BITS < 64 && |(delta >> ADDR_BITS)) || sum[ADDR_BITS];
  assign in_rng  = ({16'd0, sum[ADDR_BITS-1:0]} >= {16'd0, range_start_r})
                && ({16'd0, sum[ADDR_BITS-1:0]} < {16'd0, range_end_r})
                && (sum[1:0] == 2'b00);
  assign mid     = lo_r + ((hi_r - lo_r) >> 1);
  assign pc_trunc = ADDR_BITS'({16'd0, q_word.trap_pc});

  assign q_ready   = state_r == S_IDLE && !clr_r;
  assign out_valid = state_r == S_OUT;
  assign out_status = st_r;
  assign out_resume_pc = res_r;
  assign out_entry_index = idx_r;
  assign out_hit_order = ord_r;
  assign out_hit_offset = off_r;
  assign out_entry_count = cnt_out_r;

  // main control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; accum_r <= '0; shift_r <= '0; run_r <= '0;
      done_r <= 1'b0; err_r <= 1'b0; count_r <= '0; hits_r <= '0;
      range_start_r <= '0; range_end_r <= '0;
      load_slide_r <= '0; clr_r <= 1'b1; clr_ptr_r <= '0;
    end else begin
      // seen mark clearing sweep after reset
      if (clr_r) begin
        clr_ptr_r <= clr_ptr_r + 1'b1;
        if (clr_ptr_r == IW'(MAX_STARTS - 1)) clr_r <= 1'b0;
      end
      // register writes
      if (cfg_valid && cfg_hit) begin
        case (cfg_index)
          REG_TEXT_BASE: begin
            run_r <= ADDR_BITS'({16'd0, cfg_data});
          end
          REG_RANGE_START: range_start_r <= cfg_data;
          REG_RANGE_END:   range_end_r <= cfg_data;
          REG_LOAD_SLIDE:  load_slide_r <= cfg_data;
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: if (q_valid && !clr_r) begin
          res_r <= '0; idx_r <= '0; ord_r <= '0; off_r <= '0;
          cnt_out_r <= 13'(count_r);
          if (!q_word.is_trap) begin
            state_r <= S_OUT;
            if (err_r) st_r <= ST_ERROR;
            else if (done_r) st_r <= ST_DONE;
            else if (q_word.byte_value[7]) begin
              accum_r <= acc_nxt; shift_r <= sh_nxt;
              if (sh_nxt >= 7'd64 || q_word.last_byte) begin
                err_r <= 1'b1; st_r <= ST_ERROR;
              end else st_r <= ST_CONSUMED;
            end else begin
              accum_r <= '0; shift_r <= '0;
              if (delta == 64'd0) begin
                done_r <= 1'b1; st_r <= ST_DONE;
              end else if (ovf) begin
                err_r <= 1'b1; st_r <= ST_ERROR;
              end else begin
                run_r <= sum[ADDR_BITS-1:0];
                st_r <= ST_CONSUMED;
                if (in_rng) begin
                  if (count_r < CAP) begin
                    start_mem[count_r[IW-1:0]] <= sum[ADDR_BITS-1:0];
                    count_r <= count_r + 1'b1;
                    cnt_out_r <= 13'(count_r + 1'b1);
                    st_r <= ST_APPENDED;
                  end else st_r <= ST_FULL;
                end
                if (q_word.last_byte) done_r <= 1'b1;
              end
            end
          end else if (!done_r || err_r || count_r == '0) begin
            st_r <= ST_NOTREADY; state_r <= S_OUT;
          end else begin
            key_r <= pc_trunc; pc_r <= {1'b0, pc_trunc};
            retry_r <= 1'b0; lo_r <= '0; hi_r <= count_r;
            state_r <= S_SRCH;
          end
        end
        // one probe: read table at mid, or the final read at lo
        S_SRCH: begin
          if (lo_r < hi_r) begin
            rd_r <= start_mem[mid[IW-1:0]];
            state_r <= S_RD;
          end else if (lo_r < count_r) begin
            rd_r <= start_mem[lo_r[IW-1:0]];
            seen_rd_r <= seen_mem[lo_r[IW-1:0]];
            state_r <= S_CMP;
          end else state_r <= S_CMP;
        end
        S_RD: begin
          if (rd_r < key_r) lo_r <= mid + 1'b1;
          else hi_r <= mid;
          state_r <= S_SRCH;
        end
        S_CMP: begin
          if (lo_r < count_r && rd_r == key_r) begin
            res_r <= 48'({16'd0, key_r});
            idx_r <= 12'(lo_r);
            off_r <= 48'({16'd0, key_r}) - load_slide_r;
            state_r <= S_MARK;
          end else if (!retry_r && pc_r >= (ADDR_BITS+1)'(4)) begin
            retry_r <= 1'b1; key_r <= pc_r[ADDR_BITS-1:0] - ADDR_BITS'(4);
            lo_r <= '0; hi_r <= count_r; state_r <= S_SRCH;
          end else begin
            st_r <= ST_NOMATCH; state_r <= S_OUT;
          end
        end
        S_MARK: begin
          if (!seen_rd_r) begin
            seen_mem[lo_r[IW-1:0]] <= 1'b1;
            ord_r <= 12'(hits_r); hits_r <= hits_r + 1'b1;
            st_r <= ST_FIRST;
          end else st_r <= ST_REPEAT;
          state_r <= S_OUT;
        end
        S_OUT: if (out_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
      if (clr_r) seen_mem[clr_ptr_r] <= 1'b0;
    end
  end
endmodule
`default_nettype wire

// ===== tb/function_start_table_hit_recorder_test.sv =====
// testbench for the function start table hit recorder: random and directed words,
// a built-in predictor of the table builder and trap lookup, field-by-field checks
// depends on fsthr_pkg and function_start_table_hit_recorder
`timescale 1ns / 1ps
module function_start_table_hit_recorder_test import fsthr_pkg::*;;

  localparam int TBL_DEPTH = 4096;
  localparam logic [47:0] ADDR_ALL = 48'hffff_ffff_ffff;
  localparam int LIMIT_CYCLES = 2000000;

  typedef struct packed {
    logic        is_trap;
    logic [7:0]  value;
    logic        last;
    logic [47:0] pc;
  } word_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [47:0] resume_pc;
    logic [11:0] entry_index;
    logic [11:0] hit_order;
    logic [47:0] hit_offset;
    logic [12:0] entry_count;
  } outcome_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0, in_req_type = 0, in_last_byte = 0;
  logic [7:0] in_byte_value = 0;
  logic [47:0] in_trap_pc = 0;
  logic in_ready;
  logic out_valid, out_ready = 0;
  logic [3:0] out_status;
  logic [47:0] out_resume_pc, out_hit_offset;
  logic [11:0] out_entry_index, out_hit_order;
  logic [12:0] out_entry_count;
  logic cfg_valid = 0, cfg_ready;
  logic [1:0] cfg_index = 0;
  logic [47:0] cfg_data = 0;

  function_start_table_hit_recorder dut (.*);

  always #1 clk = ~clk;

  // predictor state
  logic [47:0] base_r, rstart_r, rend_r, slide_r;
  logic [63:0] accum;
  int unsigned shift;
  logic [47:0] run_addr;
  bit done_f, err_f;
  int unsigned count;
  logic [47:0] starts [TBL_DEPTH];
  bit seen [TBL_DEPTH];
  int unsigned hits;

  word_t pending_words[$];
  outcome_t expected_outcomes[$];
  int errors = 0;
  int cycles = 0;
  int received = 0;
  bit idle_ok = 1;
  int hold_cycles = 0;
  int n_first = 0, n_append = 0;

  function automatic bit find_start(logic [47:0] a, output int unsigned pos);
    int unsigned lo, hi, mid;
    lo = 0; hi = count;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (starts[mid] < a) lo = mid + 1;
      else hi = mid;
    end
    pos = lo;
    return lo < count && starts[lo] == a;
  endfunction

  function automatic logic [3:0] take_byte(logic [7:0] b, logic last);
    logic [63:0] delta;
    logic [3:0] st;
    if (err_f) return ST_ERROR;
    if (done_f) return ST_DONE;
    if (shift < 64) accum |= 64'(b[6:0]) << shift;
    if (b[7]) begin
      shift += 7;
      if (shift >= 64 || last) begin
        err_f = 1;
        return ST_ERROR;
      end
      return ST_CONSUMED;
    end
    delta = accum; accum = 0; shift = 0;
    if (delta == 0) begin
      done_f = 1;
      return ST_DONE;
    end
    if (delta > 64'(ADDR_ALL - run_addr)) begin
      err_f = 1;
      return ST_ERROR;
    end
    run_addr += delta[47:0];
    st = ST_CONSUMED;
    if (run_addr >= rstart_r && run_addr < rend_r && run_addr[1:0] == 0) begin
      if (count < TBL_DEPTH) begin
        starts[count] = run_addr;
        count++;
        st = ST_APPENDED;
      end else st = ST_FULL;
    end
    if (last) done_f = 1;
    return st;
  endfunction

  function automatic outcome_t predict_outcome(word_t w);
    outcome_t o;
    logic [47:0] a;
    int unsigned pos;
    bit hit;
    o = '0;
    if (!w.is_trap) o.status = take_byte(w.value, w.last);
    else if (!done_f || err_f || count == 0) o.status = ST_NOTREADY;
    else begin
      a = w.pc;
      hit = find_start(a, pos);
      if (!hit && w.pc >= 4) begin
        a = w.pc - 4;
        hit = find_start(a, pos);
      end
      if (!hit) o.status = ST_NOMATCH;
      else begin
        o.resume_pc = a;
        o.entry_index = pos[11:0];
        o.hit_offset = a - slide_r;
        if (!seen[pos]) begin
          seen[pos] = 1;
          o.hit_order = hits[11:0];
          hits++;
          o.status = ST_FIRST;
        end else o.status = ST_REPEAT;
      end
    end
    o.entry_count = count[12:0];
    return o;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_outcomes.push_back(predict_outcome(
          {in_req_type, in_byte_value, in_last_byte, in_trap_pc}));
      end
      if (!in_valid || in_ready) begin
        if (pending_words.size() > 0 && (idle_ok ? $urandom_range(99) >= 35 : 1)) begin
          word_t w;
          w = pending_words.pop_front();
          in_valid <= 1;
          in_req_type <= w.is_trap;
          in_byte_value <= w.value;
          in_last_byte <= w.last;
          in_trap_pc <= w.pc;
        end else in_valid <= 0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout at %0t", $time);
      $display("Mismatches found");
      $finish;
    end
    if (rst_n) begin
      if (out_valid && out_ready) begin
        outcome_t got, exp_o;
        got = {out_status, out_resume_pc, out_entry_index, out_hit_order,
               out_hit_offset, out_entry_count};
        received++;
        if (expected_outcomes.size() == 0) begin
          errors++;
          $display("%0t: unexpected word, expected none, actual %h", $time, got);
        end else begin
          exp_o = expected_outcomes.pop_front();
          if (got.status == ST_FIRST) n_first++;
          if (got.status == ST_APPENDED) n_append++;
          if (got.status != exp_o.status) begin errors++;
            $display("%0t: status exp %0d act %0d", $time, exp_o.status, got.status); end
          if (got.resume_pc != exp_o.resume_pc) begin errors++;
            $display("%0t: resume_pc exp %h act %h", $time, exp_o.resume_pc,
                     got.resume_pc); end
          if (got.entry_index != exp_o.entry_index) begin errors++;
            $display("%0t: entry_index exp %0d act %0d", $time, exp_o.entry_index,
                     got.entry_index); end
          if (got.hit_order != exp_o.hit_order) begin errors++;
            $display("%0t: hit_order exp %0d act %0d", $time, exp_o.hit_order,
                     got.hit_order); end
          if (got.hit_offset != exp_o.hit_offset) begin errors++;
            $display("%0t: hit_offset exp %h act %h", $time, exp_o.hit_offset,
                     got.hit_offset); end
          if (got.entry_count != exp_o.entry_count) begin errors++;
            $display("%0t: entry_count exp %0d act %0d", $time, exp_o.entry_count,
                     got.entry_count); end
        end
      end
      // receiver stall, with a long hold-off on request
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready <= 0;
      end else out_ready <= idle_ok ? ($urandom_range(99) >= 35) : 1'b1;
    end
  end

  task automatic wait_drained();
    while (pending_words.size() > 0 || in_valid || expected_outcomes.size() > 0)
      @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [47:0] val);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    case (idx)
      REG_TEXT_BASE: begin base_r = val; run_addr = val; end
      REG_RANGE_START: rstart_r = val;
      REG_RANGE_END: rend_r = val;
      default: slide_r = val;
    endcase
    @(posedge clk);
  endtask

  task automatic push_byte(logic [7:0] b, logic last);
    pending_words.push_back({1'b0, b, last, 48'($urandom())});
  endtask

  task automatic push_trap(logic [47:0] pc);
    pending_words.push_back({1'b1, 8'($urandom()), 1'($urandom()), pc});
  endtask

  // encode a delta as uleb128
  task automatic push_delta(logic [63:0] d, logic last);
    do begin
      push_byte({d[63:7] != 0, d[6:0]}, last && d[63:7] == 0);
      d = d >> 7;
    end while (d != 0);
  endtask

  // new stream: n random deltas then a zero delta; rewriting text_base resets no
  // stream state (done/error), so only the first phase builds a table;
  // later phases exercise the terminal states and traps
  task automatic build_table(int n, logic [47:0] step_max);
    logic [63:0] d;
    for (int i = 0; i < n; i++) begin
      d = $urandom_range(1, 3) == 1 ? 64'($urandom_range(1, 12)) :
          64'($urandom_range(1, step_max / 4)) * 4;
      push_delta(d, 0);
    end
    push_delta(0, 0);
  endtask

  task automatic push_traps(int n, logic [47:0] lo, logic [47:0] span);
    logic [47:0] p;
    for (int i = 0; i < n; i++) begin
      p = lo + 48'($urandom_range(0, span));
      if ($urandom_range(9) == 0) p = {$urandom(), 16'($urandom())};
      push_trap(p);
    end
  endtask

  initial begin
    base_r = 0; rstart_r = 0; rend_r = 0; slide_r = 0;
    accum = 0; shift = 0; run_addr = 0; done_f = 0; err_f = 0;
    count = 0; hits = 0;
    for (int i = 0; i < TBL_DEPTH; i++) begin starts[i] = 0; seen[i] = 0; end
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // extreme register values before any stream
    write_reg(REG_TEXT_BASE, ADDR_ALL);
    write_reg(REG_RANGE_START, ADDR_ALL);
    write_reg(REG_RANGE_END, 0);
    write_reg(REG_LOAD_SLIDE, ADDR_ALL);
    write_reg(REG_TEXT_BASE, 48'h1000);
    write_reg(REG_RANGE_START, 48'h1000);
    write_reg(REG_RANGE_END, 48'h8000);
    write_reg(REG_LOAD_SLIDE, 48'h2000);

    // directed: early trap, deltas incl. multi-byte and unaligned, out of range
    push_trap(0);
    push_delta(4, 0);
    push_delta(3, 0);
    push_delta(1, 0);
    push_delta(64'h80, 0);
    push_delta(64'h200, 0);
    push_trap(48'h1004);
    push_delta(64'h7000, 0);
    push_delta(4, 1);
    push_byte(8'h05, 0);
    push_byte(8'hff, 1);
    push_trap(48'h1004);
    push_trap(48'h1004);
    push_trap(48'h1006);
    push_trap(48'h1008);
    push_trap(3);
    push_trap(ADDR_ALL);
    push_trap(48'h1088);
    wait_drained();

    // main random phase: traps, bytes after done, receiver hold-off mid way
    idle_ok = 1;
    write_reg(REG_LOAD_SLIDE, 48'($urandom()));
    // stream already done: bytes give done; traps look up the existing entries
    push_traps(60, 48'h1000, 48'h600);
    for (int i = 0; i < 20; i++) push_byte(8'($urandom()), 1'($urandom()));
    hold_cycles = 300;
    push_traps(200, 48'h1000, 48'h300);
    wait_drained();
    // sender pauses here until all results came back, then no idling stretch
    idle_ok = 0;
    push_traps(150, 48'h1000, 48'h300);
    wait_drained();
    idle_ok = 1;
    for (int i = 0; i < 60; i++) begin
      if ($urandom_range(1)) push_trap({$urandom(), 16'($urandom())});
      else push_byte(8'($urandom()), 1'($urandom()));
    end
    push_traps(200, 48'h1000, 48'h7000);
    wait_drained();

    $display("run covered %0d results, %0d appends and %0d first hits", received,
             n_append, n_first);
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
